### hdl/matrix_inverse_3x3_core_defines.svh
// assertion macros for the 3x3 matrix inverse core
// no dependencies; taken in by the top level
`ifndef MATRIX_INVERSE_3X3_CORE_DEFINES_SVH
`define MATRIX_INVERSE_3X3_CORE_DEFINES_SVH
`ifndef ASSERT_OFF
`define MI3_ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication failed");
`define MI3_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define MI3_ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define MI3_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hdl/mi3_pkg.sv
// shared widths, constants and stage types of the 3x3 matrix inverse core
// no dependencies
package mi3_pkg;
  localparam int ENTRY_W   = 16;
  localparam int FRAC      = 12;
  localparam int OUT_FRAC  = 16;
  localparam int PROD_W    = 2 * ENTRY_W;
  localparam int ADJ_W     = PROD_W + 1;
  localparam int AMAG_W    = ADJ_W - 1;
  localparam int DET_W     = ADJ_W + ENTRY_W + 1;
  localparam int DEN_W     = DET_W - 1;
  localparam int REM_W     = DEN_W + 1;
  localparam int RND_SH    = 2 * FRAC - OUT_FRAC;
  localparam int ADJQ_W    = AMAG_W - RND_SH;
  localparam int Q_W       = 32;
  localparam int DIV_STEPS = Q_W;
  localparam int NSH       = FRAC + OUT_FRAC;
  localparam int NLO_W     = Q_W - NSH;
  localparam int OVF_SH    = Q_W - NSH;
  localparam int OVF_W     = DEN_W + OVF_SH;
  localparam int THR_W     = 40;
  localparam logic [THR_W-1:0] THR_RST = 40'd68719;
  localparam int OUT_W     = 32;
  localparam int DETO_W    = 49;
  localparam int FRONT_STG = 5;
  localparam int NSTG      = FRONT_STG + DIV_STEPS + 1;
  localparam logic [OUT_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [OUT_W-1:0] NEG_MAX = 32'h8000_0000;

  // product operand indexes, adjugate entry k = pp[2k] - pp[2k+1]
  localparam int unsigned PA [18] = '{4,5,2,1,1,2,5,3,0,2,2,0,3,4,1,0,0,1};
  localparam int unsigned PB [18] = '{8,7,7,8,5,4,6,8,8,6,3,5,7,6,6,7,4,3};

  typedef struct packed {
    logic              neg;
    logic              ovf;
    logic              sing;
    logic [ADJQ_W-1:0] adjq;
    logic [REM_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [NLO_W-1:0]  nlo;
    logic [Q_W-1:0]    q;
  } lane_t;

  typedef struct packed {
    logic                    sing;
    logic signed [DET_W-1:0] det;
  } ctl_t;
endpackage

### hdl/mi3_front.sv
// adjugate, determinant and divider setup: five register stages
// depends on mi3_pkg
module mi3_front (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [mi3_pkg::ENTRY_W-1:0]   m_i [9],
  input  logic [mi3_pkg::THR_W-1:0]            thr_i,
  output mi3_pkg::lane_t                       lane_o [9],
  output mi3_pkg::ctl_t                        ctl_o
);
  import mi3_pkg::*;

  logic signed [PROD_W-1:0]  pp_r   [18];
  logic signed [ENTRY_W-1:0] m1_r   [3];
  logic signed [ADJ_W-1:0]   adj2_r [9];
  logic signed [ENTRY_W-1:0] m2_r   [3];
  logic signed [DET_W-2:0]   dp3_r  [3];
  logic signed [ADJ_W-1:0]   adj3_r [9];
  logic signed [DET_W-1:0]   det4_r;
  logic signed [ADJ_W-1:0]   adj4_r [9];
  lane_t                     lane_r [9];
  ctl_t                      ctl_r;

  logic [DET_W-1:0]  det_neg_v;
  logic              det_neg;
  logic [DEN_W-1:0]  det_mag;
  logic              sing;

  assign det_neg   = det4_r[DET_W-1];
  assign det_neg_v = -det4_r;
  assign det_mag   = det_neg ? det_neg_v[DEN_W-1:0] : det4_r[DEN_W-1:0];
  assign sing      = (det_mag == '0) || (det_mag < DEN_W'(thr_i));

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 18; k++) begin
        pp_r[k] <= m_i[PA[k]] * m_i[PB[k]];
      end
      for (int j = 0; j < 3; j++) begin
        m1_r[j] <= m_i[j];
        m2_r[j] <= m1_r[j];
      end
      for (int k = 0; k < 9; k++) begin
        adj2_r[k] <= ADJ_W'(pp_r[2*k]) - ADJ_W'(pp_r[2*k+1]);
        adj3_r[k] <= adj2_r[k];
        adj4_r[k] <= adj3_r[k];
      end
      for (int j = 0; j < 3; j++) begin
        dp3_r[j] <= m2_r[j] * adj2_r[3*j];
      end
      det4_r <= DET_W'(dp3_r[0]) + DET_W'(dp3_r[1]) + DET_W'(dp3_r[2]);
      ctl_r.sing <= sing;
      ctl_r.det  <= det4_r;
    end
  end

  for (genvar k = 0; k < 9; k++) begin : g_setup
    logic              a_neg;
    logic [ADJ_W-1:0]  a_neg_v;
    logic [AMAG_W-1:0] a_mag;
    logic [AMAG_W:0]   a_rnd;
    assign a_neg   = adj4_r[k][ADJ_W-1];
    assign a_neg_v = -adj4_r[k];
    assign a_mag   = a_neg ? a_neg_v[AMAG_W-1:0] : adj4_r[k][AMAG_W-1:0];
    assign a_rnd   = {1'b0, a_mag} + (AMAG_W+1)'(1 << (RND_SH - 1));
    always_ff @(posedge clk) begin
      if (en) begin
        lane_r[k].neg  <= a_neg ^ (!sing && det_neg);
        lane_r[k].ovf  <= OVF_W'(a_mag) >= {det_mag, OVF_SH'(0)};
        lane_r[k].sing <= sing;
        lane_r[k].adjq <= a_rnd[AMAG_W-1:RND_SH];
        lane_r[k].rem  <= REM_W'(a_mag[AMAG_W-1:NLO_W]);
        lane_r[k].den  <= det_mag;
        lane_r[k].nlo  <= a_mag[NLO_W-1:0];
        lane_r[k].q    <= '0;
      end
    end
  end

  assign lane_o = lane_r;
  assign ctl_o  = ctl_r;
endmodule

### hdl/mi3_div_lane.sv
// one restoring divider lane, one quotient bit per stage, with rounding,
// saturation and the singular bypass at the end; depends on mi3_pkg
module mi3_div_lane (
  input  logic                       clk,
  input  logic                       en,
  input  mi3_pkg::lane_t             lane_i,
  output logic [mi3_pkg::OUT_W-1:0]  r_o
);
  import mi3_pkg::*;

  lane_t st [DIV_STEPS+1];

  assign st[0] = lane_i;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    localparam int BI = Q_W - 1 - k;
    logic             b;
    logic [REM_W-1:0] trial;
    logic             ge;
    lane_t            step_nxt;
    if (BI >= Q_W - NLO_W) begin : g_bit
      assign b = st[k].nlo[BI-(Q_W-NLO_W)];
    end else begin : g_zero
      assign b = 1'b0;
    end
    assign trial = {st[k].rem[REM_W-2:0], b};
    assign ge    = trial >= REM_W'(st[k].den);
    always_comb begin
      step_nxt     = st[k];
      step_nxt.rem = ge ? trial - REM_W'(st[k].den) : trial;
      step_nxt.q   = {st[k].q[Q_W-2:0], ge};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= step_nxt;
      end
    end
  end

  lane_t            f;
  logic             rnd;
  logic [Q_W:0]     qr;
  logic [OUT_W-1:0] pos_v;
  logic [OUT_W-1:0] neg_v;
  logic [OUT_W-1:0] sq;

  assign f     = st[DIV_STEPS];
  assign rnd   = {f.rem, 1'b0} >= (REM_W+1)'(f.den);
  assign qr    = {1'b0, f.q} + (Q_W+1)'(rnd);
  assign pos_v = (f.ovf || qr > (Q_W+1)'(POS_MAX)) ? POS_MAX : qr[OUT_W-1:0];
  assign neg_v = (f.ovf || qr > (Q_W+1)'(NEG_MAX)) ? NEG_MAX : -qr[OUT_W-1:0];
  assign sq    = OUT_W'(f.adjq);

  always_comb begin
    if (f.sing) begin
      r_o = f.neg ? -sq : sq;
    end else begin
      r_o = f.neg ? neg_v : pos_v;
    end
  end
endmodule

### hdl/matrix_inverse_3x3_core.sv
// top level of the 3x3 matrix inverse core: adjugate front end, nine
// divider lanes, output register; depends on mi3_pkg, mi3_front, mi3_div_lane
//
//   channel | dir | handshake          | payload
//   in      | in  | in_valid/in_stall  | in_m00 .. in_m22, signed Q4.12
//   out     | out | out_valid/out_stall| out_r00 .. out_r22, determinant, singular
//   cfg     | in  | cfg_valid/cfg_ready| cfg_data, singular threshold
//
// one item per cycle unless out_stall holds a waiting result; 5 front stages, 32 divider
// stages, 1 output register; the divider depth is set by the one-bit-per-stage quotient
// out_stall with a waiting result freezes the whole pipeline and raises in_stall
// synchronous active-low reset clears valid bits and sets the threshold to 68719
// cfg_ready is always high
`include "matrix_inverse_3x3_core_defines.svh"
module matrix_inverse_3x3_core (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mi3_pkg::ENTRY_W-1:0]  in_m00,
  input  logic signed [mi3_pkg::ENTRY_W-1:0]  in_m01,
  input  logic signed [mi3_pkg::ENTRY_W-1:0]  in_m02,
  input  logic signed [mi3_pkg::ENTRY_W-1:0]  in_m10,
  input  logic signed [mi3_pkg::ENTRY_W-1:0]  in_m11,
  input  logic signed [mi3_pkg::ENTRY_W-1:0]  in_m12,
  input  logic signed [mi3_pkg::ENTRY_W-1:0]  in_m20,
  input  logic signed [mi3_pkg::ENTRY_W-1:0]  in_m21,
  input  logic signed [mi3_pkg::ENTRY_W-1:0]  in_m22,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mi3_pkg::OUT_W-1:0]    out_r00,
  output logic signed [mi3_pkg::OUT_W-1:0]    out_r01,
  output logic signed [mi3_pkg::OUT_W-1:0]    out_r02,
  output logic signed [mi3_pkg::OUT_W-1:0]    out_r10,
  output logic signed [mi3_pkg::OUT_W-1:0]    out_r11,
  output logic signed [mi3_pkg::OUT_W-1:0]    out_r12,
  output logic signed [mi3_pkg::OUT_W-1:0]    out_r20,
  output logic signed [mi3_pkg::OUT_W-1:0]    out_r21,
  output logic signed [mi3_pkg::OUT_W-1:0]    out_r22,
  output logic signed [mi3_pkg::DETO_W-1:0]   out_determinant,
  output logic                                out_singular,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mi3_pkg::THR_W-1:0]           cfg_data
);
  import mi3_pkg::*;

  logic                      en;
  logic [NSTG-1:0]           v_r;
  logic [NSTG-1:0]           v_nxt;
  logic [THR_W-1:0]          thr_r;
  logic signed [ENTRY_W-1:0] m_in [9];
  lane_t                     lane [9];
  ctl_t                      ctl_f;
  ctl_t                      ctl_r [DIV_STEPS];
  logic [OUT_W-1:0]          r_lane [9];
  logic [OUT_W-1:0]          r_r [9];
  logic [DETO_W-1:0]         det_r;
  logic                      sing_r;

  assign en        = !(v_r[NSTG-1] && out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;
  assign v_nxt     = en ? {v_r[NSTG-2:0], in_valid} : v_r;

  assign m_in = '{in_m00, in_m01, in_m02, in_m10, in_m11, in_m12, in_m20, in_m21, in_m22};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= '0;
      thr_r <= THR_RST;
    end else begin
      v_r <= v_nxt;
      if (cfg_valid && cfg_ready) begin
        thr_r <= cfg_data;
      end
    end
  end

  mi3_front u_front (
    .clk    (clk),
    .en     (en),
    .m_i    (m_in),
    .thr_i  (thr_r),
    .lane_o (lane),
    .ctl_o  (ctl_f)
  );

  for (genvar k = 0; k < 9; k++) begin : g_lane
    mi3_div_lane u_lane (
      .clk    (clk),
      .en     (en),
      .lane_i (lane[k]),
      .r_o    (r_lane[k])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl_r[0] <= ctl_f;
      for (int j = 1; j < DIV_STEPS; j++) begin
        ctl_r[j] <= ctl_r[j-1];
      end
      r_r    <= r_lane;
      det_r  <= ctl_r[DIV_STEPS-1].det[DETO_W-1:0];
      sing_r <= ctl_r[DIV_STEPS-1].sing;
    end
  end

  assign out_valid       = v_r[NSTG-1];
  assign out_r00         = r_r[0];
  assign out_r01         = r_r[1];
  assign out_r02         = r_r[2];
  assign out_r10         = r_r[3];
  assign out_r11         = r_r[4];
  assign out_r12         = r_r[5];
  assign out_r20         = r_r[6];
  assign out_r21         = r_r[7];
  assign out_r22         = r_r[8];
  assign out_determinant = det_r;
  assign out_singular    = sing_r;

  `MI3_ASSERT_IMPLY(a_nonsing_det, clk, rst_n, out_valid && !out_singular, out_determinant != '0)
  `MI3_ASSERT_NEXT(a_lane_to_out, clk, rst_n, en && v_r[NSTG-2], out_valid)
  `MI3_ASSERT_NEXT(a_hold_valid, clk, rst_n, out_valid && out_stall, out_valid && $stable(det_r))
endmodule

### sim/tb_top.sv
// self-checking bench for matrix_inverse_3x3_core: random and corner matrices,
// predicted inverse/adjugate, determinant and singular flag compared per item
// depends on mi3_pkg and matrix_inverse_3x3_core
module tb_top;
  import mi3_pkg::*;

  typedef struct {
    logic signed [ENTRY_W-1:0] m [9];
  } mat_t;

  typedef struct {
    logic [OUT_W-1:0]  r [9];
    logic [DETO_W-1:0] det;
    logic              sing;
  } inv_t;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  logic signed [ENTRY_W-1:0] in_m [9];
  logic signed [OUT_W-1:0] out_r [9];
  logic signed [DETO_W-1:0] out_determinant;
  logic out_singular;
  logic [THR_W-1:0] cfg_data;
  logic in_stall_s;

  mat_t pending_mats[$];
  inv_t expected_inv[$];
  logic [THR_W-1:0] threshold;
  int errors;
  int gap_left;
  int stall_left;
  bit stall_on;

  matrix_inverse_3x3_core dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_m00(in_m[0]), .in_m01(in_m[1]), .in_m02(in_m[2]),
    .in_m10(in_m[3]), .in_m11(in_m[4]), .in_m12(in_m[5]),
    .in_m20(in_m[6]), .in_m21(in_m[7]), .in_m22(in_m[8]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_r00(out_r[0]), .out_r01(out_r[1]), .out_r02(out_r[2]),
    .out_r10(out_r[3]), .out_r11(out_r[4]), .out_r12(out_r[5]),
    .out_r20(out_r[6]), .out_r21(out_r[7]), .out_r22(out_r[8]),
    .out_determinant(out_determinant), .out_singular(out_singular),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic logic [OUT_W-1:0] sat_q16(bit neg, logic [63:0] m);
    if (neg) begin
      if (m > 64'h8000_0000) m = 64'h8000_0000;
      return OUT_W'(64'd0 - m);
    end
    if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
    return OUT_W'(m);
  endfunction

  function automatic inv_t predict_inverse(mat_t x, logic [THR_W-1:0] thr);
    inv_t res;
    longint m [9];
    longint a [9];
    longint d, av;
    logic [63:0] dm, am, num, q, rm;
    bit neg;
    for (int i = 0; i < 9; i++) m[i] = x.m[i];
    a[0] = m[4]*m[8] - m[5]*m[7];
    a[3] = m[5]*m[6] - m[3]*m[8];
    a[6] = m[3]*m[7] - m[4]*m[6];
    a[1] = m[2]*m[7] - m[1]*m[8];
    a[4] = m[0]*m[8] - m[2]*m[6];
    a[7] = m[1]*m[6] - m[0]*m[7];
    a[2] = m[1]*m[5] - m[2]*m[4];
    a[5] = m[2]*m[3] - m[0]*m[5];
    a[8] = m[0]*m[4] - m[1]*m[3];
    d = m[0]*a[0] + m[1]*a[3] + m[2]*a[6];
    dm = (d < 0) ? -d : d;
    res.sing = (d == 0) || (dm < {24'd0, thr});
    res.det = DETO_W'(d);
    for (int i = 0; i < 9; i++) begin
      av = a[i];
      am = (av < 0) ? -av : av;
      if (res.sing) begin
        res.r[i] = sat_q16(av < 0, (am + 64'd128) >> 8);
      end else begin
        neg = (av < 0) != (d < 0);
        num = am << 28;
        q = num / dm;
        rm = num % dm;
        if (rm >= dm - rm) q++;
        res.r[i] = sat_q16(neg, q);
      end
    end
    return res;
  endfunction

  function automatic logic signed [ENTRY_W-1:0] rand_entry();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sd0;
      3, 4: return ENTRY_W'($signed($urandom_range(0, 8192)) - 4096);
      default: return ENTRY_W'($urandom);
    endcase
  endfunction

  task automatic add_mat(mat_t x);
    pending_mats.push_back(x);
  endtask

  task automatic wait_drained();
    while (pending_mats.size() != 0 || expected_inv.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    @(negedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    threshold = v;
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic run_random(int n);
    mat_t x;
    int mode;
    for (int k = 0; k < n; k++) begin
      mode = $urandom_range(0, 9);
      for (int i = 0; i < 9; i++) x.m[i] = rand_entry();
      if (mode == 0) begin
        for (int i = 0; i < 3; i++) x.m[6+i] = x.m[i];
      end else if (mode == 1) begin
        for (int i = 0; i < 9; i++) x.m[i] = (i % 4 == 0) ? rand_entry() : 16'sd0;
      end else if (mode == 2) begin
        for (int i = 0; i < 9; i++) x.m[i] = ENTRY_W'($signed($urandom_range(0, 16)) - 8);
      end
      add_mat(x);
    end
  endtask

  initial begin
    mat_t x;
    rst_n = 0;
    in_valid = 0;
    out_stall = 0;
    cfg_valid = 0;
    cfg_data = '0;
    for (int i = 0; i < 9; i++) in_m[i] = '0;
    threshold = THR_RST;
    errors = 0;
    gap_left = 0;
    stall_left = 0;
    stall_on = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // identity, zero, extremes, singular, tiny determinant
    for (int i = 0; i < 9; i++) x.m[i] = (i % 4 == 0) ? 16'sd4096 : 16'sd0;
    add_mat(x);
    for (int i = 0; i < 9; i++) x.m[i] = 16'sd0;
    add_mat(x);
    for (int i = 0; i < 9; i++) x.m[i] = (i % 4 == 0) ? 16'sh7FFF : 16'sd0;
    add_mat(x);
    for (int i = 0; i < 9; i++) x.m[i] = (i % 4 == 0) ? 16'sh8000 : 16'sd0;
    add_mat(x);
    for (int i = 0; i < 9; i++) x.m[i] = (i % 4 == 0) ? 16'sd1 : 16'sd0;
    add_mat(x);
    for (int i = 0; i < 9; i++) x.m[i] = (i % 4 == 0) ? 16'sd16 : 16'sd0;
    add_mat(x);
    for (int i = 0; i < 9; i++) x.m[i] = (i % 4 == 0) ? 16'sd17 : 16'sd0;
    add_mat(x);
    for (int i = 0; i < 9; i++) x.m[i] = (i % 2 == 0) ? 16'sh8000 : 16'sh7FFF;
    add_mat(x);
    for (int i = 0; i < 9; i++) x.m[i] = 16'(i + 1) <<< 12;
    add_mat(x);
    for (int i = 0; i < 9; i++) x.m[i] = (i % 4 == 0) ? -16'sd4096 : 16'sd3;
    add_mat(x);
    x.m = '{16'sd2, 16'sd0, 16'sd0, 16'sd0, 16'sd3, 16'sd0, 16'sd0, 16'sd0, 16'sd5};
    add_mat(x);
    wait_drained();

    write_threshold('0);
    for (int i = 0; i < 9; i++) x.m[i] = (i % 4 == 0) ? 16'sd1 : 16'sd0;
    add_mat(x);
    for (int i = 0; i < 9; i++) x.m[i] = 16'sd0;
    add_mat(x);
    run_random(250);
    wait_drained();

    write_threshold({THR_W{1'b1}});
    run_random(200);
    wait_drained();

    write_threshold(40'd1 << 36);
    run_random(250);
    wait_drained();

    write_threshold(THR_W'({$urandom, $urandom}));
    run_random(50);
    wait_drained();

    write_threshold(THR_RST);
    run_random(250);
    wait_drained();

    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #10000000;
    $display("FAIL");
    $finish;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall_s) begin
        if (gap_left == 0 && pending_mats.size() != 0) begin
          for (int i = 0; i < 9; i++) in_m[i] <= pending_mats[0].m[i];
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end else if (!in_valid) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (pending_mats.size() != 0) begin
          for (int i = 0; i < 9; i++) in_m[i] <= pending_mats[0].m[i];
          in_valid <= 1;
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
      end else begin
        stall_on <= ($urandom_range(0, 3) == 0);
        stall_left <= ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
                      $urandom_range(0, 3);
      end
      out_stall <= stall_on;
    end
  end

  // acceptance on the rising edge
  always @(posedge clk) begin
    in_stall_s <= in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_inv.push_back(predict_inverse(pending_mats.pop_front(), threshold));
      if ($urandom_range(0, 2) == 0) begin
        gap_left <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 50) :
                    $urandom_range(1, 3);
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    inv_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_inv.size() == 0) begin
        $display("%0t: unexpected item, actual det %h", $time, out_determinant);
        errors++;
      end else begin
        e = expected_inv.pop_front();
        for (int i = 0; i < 9; i++)
          if (out_r[i] !== e.r[i]) begin
            $display("%0t: r%0d%0d expected %h actual %h", $time, i / 3, i % 3,
                     e.r[i], out_r[i]);
            errors++;
          end
        if (out_determinant !== e.det) begin
          $display("%0t: determinant expected %h actual %h", $time, e.det,
                   out_determinant);
          errors++;
        end
        if (out_singular !== e.sing) begin
          $display("%0t: singular expected %b actual %b", $time, e.sing, out_singular);
          errors++;
        end
      end
    end
  end
endmodule
